>>> design/box_blur_3x3_edge_aware_macros.svh
// ----------------------------------------------------------------------------
// box blur assertion macros
// shared property forms for the blur block checks
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// condition holds at every clock edge out of reset
`define BB3_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BB3_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// types and constants shared by the 3x3 box blur modules
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // sum of up to nine 8-bit values, and the count of summed pixels
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;

  // mean = (2*sum + n) / (2*n) as ((2*sum + n) * M) >> RECIP_SHIFT
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // one line-store entry: rows two above and one above the incoming row
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_col_t;

  // which neighbourhood sides lie inside the frame
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_mask_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_SCALE
  } state_t;

  // ceil(2^RECIP_SHIFT / (2*n)); exact for every dividend below 2^13
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    unique case (count)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

>>> design/bb3_linebuf.sv
// ----------------------------------------------------------------------------
// bb3_linebuf
// line store: one entry per column holding the two previous rows
// ----------------------------------------------------------------------------
module bb3_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output bb3_pkg::line_col_t   rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  bb3_pkg::line_col_t   wr_data
);

  bb3_pkg::line_col_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 pixel window with edge-masked per-channel sums
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic                          clk,
  input  logic                          shift,
  input  bb3_pkg::pixel_t               col_top,
  input  bb3_pkg::pixel_t               col_mid,
  input  bb3_pkg::pixel_t               col_new,
  input  logic                          sum_en,
  input  bb3_pkg::edge_mask_t           mask,
  output logic [bb3_pkg::SUM_W-1:0]     red_sum,
  output logic [bb3_pkg::SUM_W-1:0]     green_sum,
  output logic [bb3_pkg::SUM_W-1:0]     blue_sum,
  output logic [bb3_pkg::CNT_W-1:0]     count
);

  // index = column * 3 + row, column 2 newest
  bb3_pkg::pixel_t win [9];

  logic [bb3_pkg::SUM_W-1:0] red_acc;
  logic [bb3_pkg::SUM_W-1:0] green_acc;
  logic [bb3_pkg::SUM_W-1:0] blue_acc;
  logic [bb3_pkg::CNT_W-1:0] count_acc;

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= win[i+3];
      end
      win[6] <= col_top;
      win[7] <= col_mid;
      win[8] <= col_new;
    end
  end

  always_comb begin
    logic take;
    red_acc   = '0;
    green_acc = '0;
    blue_acc  = '0;
    count_acc = '0;
    take      = 1'b0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        take = !((c == 0 && !mask.left) || (c == 2 && !mask.right) ||
                 (r == 0 && !mask.top)  || (r == 2 && !mask.bottom));
        if (take) begin
          red_acc   = red_acc   + bb3_pkg::SUM_W'(win[3*c+r].red);
          green_acc = green_acc + bb3_pkg::SUM_W'(win[3*c+r].green);
          blue_acc  = blue_acc  + bb3_pkg::SUM_W'(win[3*c+r].blue);
          count_acc = count_acc + bb3_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      red_sum   <= red_acc;
      green_sum <= green_acc;
      blue_sum  <= blue_acc;
      count     <= count_acc;
    end
  end

endmodule

>>> design/bb3_scale.sv
// ----------------------------------------------------------------------------
// bb3_scale
// rounded mean by reciprocal multiply, into the result register
// ----------------------------------------------------------------------------
module bb3_scale (
  input  logic                      clk,
  input  logic                      load,
  input  logic [bb3_pkg::SUM_W-1:0] red_sum,
  input  logic [bb3_pkg::SUM_W-1:0] green_sum,
  input  logic [bb3_pkg::SUM_W-1:0] blue_sum,
  input  logic [bb3_pkg::CNT_W-1:0] count,
  output logic [7:0]                red_mean,
  output logic [7:0]                green_mean,
  output logic [7:0]                blue_mean
);

  localparam int XW = bb3_pkg::SUM_W + 1;
  localparam int PW = XW + bb3_pkg::RECIP_W;

  logic [bb3_pkg::RECIP_W-1:0] recip;
  logic [XW-1:0] red_x;
  logic [XW-1:0] green_x;
  logic [XW-1:0] blue_x;
  logic [PW-1:0] red_prod;
  logic [PW-1:0] green_prod;
  logic [PW-1:0] blue_prod;

  assign recip = bb3_pkg::recip_of(count);

  // 2*sum + n, the rounding numerator
  assign red_x   = {red_sum,   1'b0} + XW'(count);
  assign green_x = {green_sum, 1'b0} + XW'(count);
  assign blue_x  = {blue_sum,  1'b0} + XW'(count);

  assign red_prod   = PW'(red_x)   * PW'(recip);
  assign green_prod = PW'(green_x) * PW'(recip);
  assign blue_prod  = PW'(blue_x)  * PW'(recip);

  always_ff @(posedge clk) begin
    if (load) begin
      red_mean   <= red_prod[bb3_pkg::RECIP_SHIFT +: 8];
      green_mean <= green_prod[bb3_pkg::RECIP_SHIFT +: 8];
      blue_mean  <= blue_prod[bb3_pkg::RECIP_SHIFT +: 8];
    end
  end

endmodule

>>> design/box_blur_3x3_edge_aware.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// streaming 3x3 box blur of an rgb frame with edge-aware averaging
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result is the per-channel mean, rounded
// half up, of the in-frame pixels of the 3x3 neighbourhood (4 at a corner,
// 6 on an edge, 9 inside). Results lag the input by one row plus one pixel,
// so after the last pixel of a frame the source sends drain items (kind = 1)
// to push out the remaining results; a drain sent while frame pixels are
// still expected, or after the frame is done, is taken and dropped. Steps:
// an item that yields a result goes through line store read, window update
// and write-back, neighbourhood sum, and reciprocal scale into the result
// register; an item with no result ends after the window update, and a
// dropped drain is only taken. The result register decouples the output, so
// the next item is taken while a result still waits for its transfer; a
// stalled output holds the block only when a second result is ready. Writing
// either size register restarts the frame and is taken only between items.
// The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_aware_macros.svh"

module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // input item channel
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic                               kind,
  input  logic [7:0]                         red_in,
  input  logic [7:0]                         green_in,
  input  logic [7:0]                         blue_in,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result channel
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [7:0]                         red_out,
  output logic [7:0]                         green_out,
  output logic [7:0]                         blue_out,
  output logic                               frame_end
);

  // column counter indexes the line store; width counter holds the width itself
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  // row counter runs up to height + 1 while draining
  localparam int HW = $clog2(MAX_HEIGHT + 2);

  // size registers
  logic [bb3_pkg::IMAGE_WIDTH_W-1:0]  image_width;
  logic [bb3_pkg::IMAGE_HEIGHT_W-1:0] image_height;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  // position counters
  logic [CW-1:0] in_column, in_column_next;
  logic [HW-1:0] in_row, in_row_next;
  logic [CW-1:0] out_column, out_column_next;
  logic [HW-1:0] out_row, out_row_next;

  bb3_pkg::state_t state, state_next;

  // handshake and control
  logic item_xfer;
  logic cfg_xfer;
  logic size_write;
  logic draining;
  logic ignore;
  logic rd_en;
  logic mem_wr_en;
  logic win_shift;
  logic sum_en;
  logic res_load;

  // item being processed
  bb3_pkg::pixel_t    pend_px;
  bb3_pkg::line_col_t line_rd;
  bb3_pkg::line_col_t line_wr;

  // neighbourhood decisions taken at update time
  logic                emit;
  logic                in_wrap;
  logic                out_wrap;
  logic                last;
  bb3_pkg::edge_mask_t mask_now;
  bb3_pkg::edge_mask_t mask_pend;
  logic                last_pend;

  logic [bb3_pkg::SUM_W-1:0] red_sum;
  logic [bb3_pkg::SUM_W-1:0] green_sum;
  logic [bb3_pkg::SUM_W-1:0] blue_sum;
  logic [bb3_pkg::CNT_W-1:0] count;

  // ---------------------------------------------------------------- sizes
  // zero acts as one, anything above the build limit acts as the limit
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
  end

  always_comb begin
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb3_pkg::IMAGE_WIDTH_RESET;
      image_height <= bb3_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        bb3_pkg::CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[bb3_pkg::IMAGE_WIDTH_W-1:0];
        end
        bb3_pkg::CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[bb3_pkg::IMAGE_HEIGHT_W-1:0];
        end
        default: begin
          // unknown register, write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- intake
  assign item_xfer = item_valid && item_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // only a write to one of the size registers restarts the frame
  assign size_write = cfg_xfer && ((cfg_index == bb3_pkg::CFG_IMAGE_WIDTH) ||
                                   (cfg_index == bb3_pkg::CFG_IMAGE_HEIGHT));

  // all frame pixels are in once the row counter reaches the height
  assign draining = (in_row >= eff_h);
  // a drain before the frame is complete or after it is done is dropped
  assign ignore   = (kind == bb3_pkg::KIND_DRAIN) && !draining;
  assign rd_en    = item_xfer && !ignore;

  // pixels arriving while draining count as drains and enter as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_px <= draining ? '0 : {red_in, green_in, blue_in};
    end
  end

  // ---------------------------------------------------------------- line store
  // read at in_column on intake, write back the shifted column in the update step that follows
  assign line_wr = '{upper: line_rd.middle, middle: pend_px};

  bb3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (in_column),
    .rd_data (line_rd),
    .wr_en   (mem_wr_en),
    .wr_addr (in_column),
    .wr_data (line_wr)
  );

  // ---------------------------------------------------------------- window
  bb3_window u_window (
    .clk       (clk),
    .shift     (win_shift),
    .col_top   (line_rd.upper),
    .col_mid   (line_rd.middle),
    .col_new   (pend_px),
    .sum_en    (sum_en),
    .mask      (mask_pend),
    .red_sum   (red_sum),
    .green_sum (green_sum),
    .blue_sum  (blue_sum),
    .count     (count)
  );

  // ---------------------------------------------------------------- positions
  // first result once the window center reaches row 0, column 0
  assign emit = (in_row > HW'(1)) || ((in_row == HW'(1)) && (in_column != '0));

  assign in_wrap  = (WW'(in_column) + WW'(1)) >= eff_w;
  assign out_wrap = (WW'(out_column) + WW'(1)) >= eff_w;

  assign mask_now.left   = (out_column != '0);
  assign mask_now.right  = (WW'(out_column) + WW'(1)) < eff_w;
  assign mask_now.top    = (out_row != '0);
  assign mask_now.bottom = (out_row + HW'(1)) < eff_h;

  assign last = ((out_row + HW'(1)) == eff_h) && ((WW'(out_column) + WW'(1)) == eff_w);

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (size_write) begin
      // a size change restarts the frame
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end else if (state == bb3_pkg::ST_UPDATE) begin
      if (in_wrap) begin
        in_column_next = '0;
        in_row_next    = in_row + HW'(1);
      end else begin
        in_column_next = in_column + CW'(1);
      end
      if (emit) begin
        if (out_wrap) begin
          out_column_next = '0;
          out_row_next    = out_row + HW'(1);
        end else begin
          out_column_next = out_column + CW'(1);
        end
        // last result of the frame: back to the start
        if (last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // edge mask and frame end travel with the item to the sum and scale steps
  always_ff @(posedge clk) begin
    if (state == bb3_pkg::ST_UPDATE) begin
      mask_pend <= mask_now;
      last_pend <= last;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      bb3_pkg::ST_IDLE: begin
        if (rd_en) begin
          state_next = bb3_pkg::ST_UPDATE;
        end
      end
      bb3_pkg::ST_UPDATE: begin
        state_next = emit ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
      end
      bb3_pkg::ST_SUM: begin
        state_next = bb3_pkg::ST_SCALE;
      end
      bb3_pkg::ST_SCALE: begin
        if (res_load) begin
          state_next = bb3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bb3_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cfg_ready  = 1'b0;
    mem_wr_en  = 1'b0;
    win_shift  = 1'b0;
    sum_en     = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      bb3_pkg::ST_IDLE: begin
        // a pending register write goes first
        cfg_ready  = 1'b1;
        item_ready = !cfg_valid;
      end
      bb3_pkg::ST_UPDATE: begin
        mem_wr_en = 1'b1;
        win_shift = 1'b1;
      end
      bb3_pkg::ST_SUM: begin
        sum_en = 1'b1;
      end
      bb3_pkg::ST_SCALE: begin
        // wait only while the result register still holds an untaken result
        res_load = !result_valid || result_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- result
  bb3_scale u_scale (
    .clk        (clk),
    .load       (res_load),
    .red_sum    (red_sum),
    .green_sum  (green_sum),
    .blue_sum   (blue_sum),
    .count      (count),
    .red_mean   (red_out),
    .green_mean (green_out),
    .blue_mean  (blue_out)
  );

  always_ff @(posedge clk) begin
    if (res_load) begin
      frame_end <= last_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- checks
  `BB3_ASSERT_ALWAYS(a_in_column_range, clk, rst, WW'(in_column) < eff_w, "in_column past width")
  `BB3_ASSERT_ALWAYS(a_in_row_range, clk, rst, in_row <= (eff_h + HW'(1)), "in_row past drain end")
  `BB3_ASSERT_ALWAYS(a_out_behind_in, clk, rst, out_row <= in_row, "output row ahead of input")
  `BB3_ASSERT_NEXT(a_read_then_update, clk, rst, rd_en, state == bb3_pkg::ST_UPDATE, "line read not followed by update")
  `BB3_ASSERT_NEXT(a_result_not_lost, clk, rst, (state == bb3_pkg::ST_SCALE) && result_valid && !result_ready, state == bb3_pkg::ST_SCALE, "result left scale while output stalled")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the edge-aware 3x3 box blur: a shadow blur model
// predicts every output pixel from the accepted input transfers, and each
// result transfer is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
  import bb3_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int STORE_DEPTH     = 1024;    // line store depth of the block
  localparam int HEIGHT_LIMIT    = 4096;    // tallest frame the block tracks
  localparam int SETTLE_CYCLES   = 8;       // longest item occupancy: read, update, sum and scale
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 1350;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 40;

  // spare register indexes: writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // output ready patterns
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_MOSTLY
  } sink_mode_t;

  typedef struct packed {
    pixel_t mean;
    logic   frame_end;
  } blur_result_t;

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_ready;
  logic                  kind         = KIND_PIXEL;
  logic [7:0]            red_in       = '0;
  logic [7:0]            green_in     = '0;
  logic [7:0]            blue_in      = '0;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [7:0]            red_out;
  logic [7:0]            green_out;
  logic [7:0]            blue_out;
  logic                  frame_end;

  box_blur_3x3_edge_aware dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .frame_end    (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // shadow blur model
  // --------------------------------------------------------------------------
  pixel_t                    upper_store  [STORE_DEPTH];  // two rows above
  pixel_t                    middle_store [STORE_DEPTH];  // one row above
  pixel_t                    nbhd [9];    // column * 3 + row, column 2 newest
  int unsigned               in_x, in_y, out_x, out_y;
  logic [IMAGE_WIDTH_W-1:0]  width_reg;
  logic [IMAGE_HEIGHT_W-1:0] height_reg;

  blur_result_t expected_q [$];
  int unsigned  taken_items = 0;  // items that moved the block, dropped drains not counted
  int unsigned  errors      = 0;
  int unsigned  cycle_count = 0;

  // stimulus side view of the frame size in force
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned burst_left    = 0;
  bit          pace_on       = 1'b1;
  bit          hold_request  = 1'b0;

  // zero acts as one, oversize clamps to what the line store holds
  function automatic int unsigned act_width(input logic [IMAGE_WIDTH_W-1:0] v);
    if (v == 0) return 1;
    if (v > STORE_DEPTH) return STORE_DEPTH;
    return v;
  endfunction

  function automatic int unsigned act_height(input logic [IMAGE_HEIGHT_W-1:0] v);
    if (v == 0) return 1;
    if (v > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return v;
  endfunction

  function automatic void restart_frame();
    in_x  = 0;
    in_y  = 0;
    out_x = 0;
    out_y = 0;
  endfunction

  function automatic void reset_blur_model();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      upper_store[i]  = '0;
      middle_store[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    restart_frame();
    width_reg  = IMAGE_WIDTH_RESET;
    height_reg = IMAGE_HEIGHT_RESET;
  endfunction

  // any size write restarts the frame; spare indexes are ignored
  function automatic void apply_size_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = data[IMAGE_WIDTH_W-1:0];
        restart_frame();
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = data[IMAGE_HEIGHT_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // advance the model by one accepted item, queue the output pixel if any
  function automatic void predict_blur(input logic k, input pixel_t px);
    int unsigned  w, h, idx, n, sum_r, sum_g, sum_b;
    pixel_t       incoming, top, mid;
    logic         draining, emit, has_left, has_right, has_top, has_bottom, skip;
    blur_result_t res;
    w = act_width(width_reg);
    h = act_height(height_reg);
    draining = (in_y >= h);
    // drain while pixels are still owed, or after the frame is out: dropped
    if (k == KIND_DRAIN && !draining) return;
    taken_items++;
    incoming = draining ? pixel_t'('0) : px;

    idx = (in_x < STORE_DEPTH) ? in_x : STORE_DEPTH - 1;
    top = upper_store[idx];
    mid = middle_store[idx];
    upper_store[idx]  = mid;
    middle_store[idx] = incoming;

    for (int i = 0; i < 6; i++) nbhd[i] = nbhd[i + 3];
    nbhd[6] = top;
    nbhd[7] = mid;
    nbhd[8] = incoming;

    // output lags input by one row plus one pixel
    emit = (in_y > 1) || (in_y == 1 && in_x >= 1);
    in_x++;
    if (in_x >= w) begin
      in_x = 0;
      in_y++;
    end
    if (!emit) return;

    has_left   = (out_x > 0);
    has_right  = (out_x + 1 < w);
    has_top    = (out_y > 0);
    has_bottom = (out_y + 1 < h);
    n     = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        skip = (c == 0 && !has_left) || (c == 2 && !has_right) ||
               (r == 0 && !has_top)  || (r == 2 && !has_bottom);
        if (!skip) begin
          sum_r += nbhd[c * 3 + r].red;
          sum_g += nbhd[c * 3 + r].green;
          sum_b += nbhd[c * 3 + r].blue;
          n++;
        end
      end
    end
    // mean rounded half up, exact in integers
    res.mean.red   = 8'((2 * sum_r + n) / (2 * n));
    res.mean.green = 8'((2 * sum_g + n) / (2 * n));
    res.mean.blue  = 8'((2 * sum_b + n) / (2 * n));
    res.frame_end  = (out_y + 1 == h) && (out_x + 1 == w);
    expected_q.push_back(res);

    out_x++;
    if (out_x >= w) begin
      out_x = 0;
      out_y++;
    end
    if (res.frame_end) restart_frame();
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_result();
    blur_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d/%0d with no pixel expected",
                                red_out, green_out, blue_out));
    end else begin
      want = expected_q.pop_front();
      if (red_out !== want.mean.red)
        report_mismatch($sformatf("red_out %0d, expected %0d", red_out, want.mean.red));
      if (green_out !== want.mean.green)
        report_mismatch($sformatf("green_out %0d, expected %0d", green_out,
                                  want.mean.green));
      if (blue_out !== want.mean.blue)
        report_mismatch($sformatf("blue_out %0d, expected %0d", blue_out, want.mean.blue));
      if (frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end %0b, expected %0b", frame_end,
                                  want.frame_end));
    end
  endtask

  // every channel is sampled here at the clock edge, so the model sees each
  // transfer in the order the block does; results go before items since a result
  // can never stem from an item taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_size_write(cfg_index, cfg_data);
      if (result_valid && result_ready) check_result();
      if (item_valid && item_ready) predict_blur(kind, {red_in, green_in, blue_in});
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_count,
               expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // output side: random ready patterns, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned span;
    forever begin
      if (hold_request) begin
        result_ready <= 1'b0;
        for (int i = 0; i < HOLD_OFF_CYCLES; i++) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        mode = sink_mode_t'($urandom_range(2));
        span = $urandom_range(60, 1);
        for (int i = 0; i < span; i++) begin
          case (mode)
            SINK_OPEN: result_ready <= 1'b1;
            SINK_COIN: result_ready <= ($urandom_range(1) == 1);
            default:   result_ready <= ($urandom_range(7) != 0);
          endcase
          @(posedge clk);
          if (hold_request) break;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  function automatic logic [7:0] random_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_channel();
    p.green = random_channel();
    p.blue  = random_channel();
    return p;
  endfunction

  // one item transfer; bursts of random length with random gaps when pacing,
  // valid stays up between back-to-back items
  task automatic send_item(input logic k, input pixel_t px);
    int unsigned gap;
    if (pace_on && burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = $urandom_range(6, 0);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    item_valid <= 1'b1;
    kind       <= k;
    red_in     <= px.red;
    green_in   <= px.green;
    blue_in    <= px.blue;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic send_pixels(input int unsigned count);
    for (int i = 0; i < count; i++) send_item(KIND_PIXEL, random_pixel());
  endtask

  // drain steps; some go as pixels, which the block treats as drains
  task automatic send_drains(input int unsigned count, input int unsigned pixel_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < pixel_pct) send_item(KIND_PIXEL, random_pixel());
      else send_item(KIND_DRAIN, random_pixel());
    end
  endtask

  task automatic send_frame();
    send_pixels(frame_w * frame_h);
    send_drains(frame_w + 1, 0);
  endtask

  // all predicted pixels out, then room for an item that yields nothing
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    frame_w = act_width(IMAGE_WIDTH_W'(w));
    frame_h = act_height(IMAGE_HEIGHT_W'(h));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // registers come up at 640 x 480: the first output shows up only once a
  // full 640-pixel row plus one pixel is in, then the frame is abandoned
  task automatic test_reset_sizes();
    send_pixels(int'(IMAGE_WIDTH_RESET) + 3);
  endtask

  // hand-picked 3x3 frame with saturated and half-way values, stray drains on
  // both sides of it, then a single-row frame and a frame sized zero by zero
  task automatic test_directed_frames();
    pixel_t probe [9];
    probe = '{24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
              24'h000000, 24'h807F01, 24'h01FE80,
              24'hFF0000, 24'h0000FF, 24'h7F8081};
    set_size(3, 3);
    send_item(KIND_DRAIN, 24'hFFFFFF);   // frame not in yet: dropped
    foreach (probe[i]) send_item(KIND_PIXEL, probe[i]);
    send_item(KIND_DRAIN, 24'hFFFFFF);   // drain payload is ignored
    send_item(KIND_PIXEL, 24'hFFFFFF);   // pixel past the frame acts as a drain
    send_item(KIND_DRAIN, '0);
    send_item(KIND_DRAIN, '0);           // carries frame_end
    send_item(KIND_DRAIN, '0);           // frame already out: dropped

    // one row: the first drain step has nothing to push out
    set_size(4, 1);
    send_frame();

    // zero means one on both axes
    set_size(0, 0);
    send_item(KIND_PIXEL, 24'hFFFFFF);
    send_item(KIND_PIXEL, 24'h123456);
    send_item(KIND_DRAIN, '0);
  endtask

  // tallest register value and the widest frame the store holds, each on a partial frame
  task automatic test_size_extremes();
    set_size(1, 8191);      // clamps to the height limit
    send_pixels(10);
    set_size(3, 4096);
    send_pixels(12);
    set_size(1024, 2);
    send_pixels(6);
  endtask

  // one full frame at the widest line the store holds (2047 clamps to it)
  task automatic test_max_width();
    set_size(2047, 1);
    send_frame();
  endtask

  // writes to spare indexes land mid-frame and must not disturb it
  task automatic test_spare_index();
    set_size(4, 3);
    send_pixels(6);
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom) | CFG_DATA_W'(13'h1FFF));
    send_pixels(6);
    send_drains(frame_w + 1, 0);
  endtask

  // rewriting a size mid-frame throws the frame away and starts over
  task automatic test_frame_abort();
    set_size(5, 4);
    send_pixels(13);
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(4));
    send_frame();
  endtask

  // output held off for a long stretch while items keep coming back-to-back,
  // so the block fills and has to stall its input
  task automatic test_backpressure();
    set_size(6, 4);
    pace_on = 1'b0;
    hold_request = 1'b1;
    send_frame();
    pace_on = 1'b1;
  endtask

  // mostly well-formed small frames with random content; noise is stray
  // drains, pixels sent as drain steps, spare-index writes and aborted frames
  task automatic test_random_frames();
    int unsigned start, w, h, total, cut;
    bit          first;
    start = taken_items;
    first = 1'b1;
    while (taken_items < start + RANDOM_ITEMS) begin
      if (first || $urandom_range(2) != 0) begin
        case ($urandom_range(9))
          0:       w = $urandom_range(1);       // zero acts as one
          1:       w = 2;
          2:       w = $urandom_range(40, 9);
          default: w = $urandom_range(8, 1);
        endcase
        case ($urandom_range(7))
          0:       h = $urandom_range(1);
          1:       h = $urandom_range(12, 7);
          default: h = $urandom_range(6, 2);
        endcase
        set_size(w, h);
        first = 1'b0;
      end
      pace_on = ($urandom_range(3) != 0);
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
      if ($urandom_range(9) == 0) send_item(KIND_DRAIN, random_pixel());

      total = frame_w * frame_h;
      cut = ($urandom_range(11) == 0) ? $urandom_range(total - 1, 0) : total;
      for (int i = 0; i < cut; i++) begin
        // a drain while pixels are owed is dropped
        if ($urandom_range(19) == 0) send_item(KIND_DRAIN, random_pixel());
        send_item(KIND_PIXEL, random_pixel());
      end
      if (cut == total) begin
        send_drains(frame_w + 1, 15);
        if ($urandom_range(4) == 0) send_item(KIND_DRAIN, random_pixel());
      end else begin
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(frame_w));
      end
    end
    pace_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_blur_model();
    frame_w = act_width(IMAGE_WIDTH_RESET);
    frame_h = act_height(IMAGE_HEIGHT_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_sizes();
    test_directed_frames();
    test_size_extremes();
    test_max_width();
    test_spare_index();
    test_frame_abort();
    test_backpressure();
    test_random_frames();

    wait_idle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> box_blur_3x3_edge_aware.f
+incdir+design
design/bb3_pkg.sv
design/bb3_linebuf.sv
design/bb3_window.sv
design/bb3_scale.sv
design/box_blur_3x3_edge_aware.sv
bench/tb_top.sv
